[hw/rtl/llrs_pkg.sv]
package llrs_pkg;

  localparam int ROW_BITS   = 64;
  localparam int MASK_BITS  = 9;
  localparam int WIDTH_BITS = 7;
  localparam int CNT_BITS   = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR   = 2;
  localparam int FIFO_CNT   = 3;

  localparam logic [MASK_BITS-1:0]  BIRTH_RESET   = 9'd8;
  localparam logic [MASK_BITS-1:0]  SURVIVE_RESET = 9'd12;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 7'd64;

  typedef enum logic [1:0] {
    CFG_BIRTH   = 2'd0,
    CFG_SURVIVE = 2'd1,
    CFG_WIDTH   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                last_row;
  } in_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_cells;
    logic                row_changed;
    logic                board_unchanged;
    logic                final_row;
  } out_t;

  typedef struct packed {
    logic push0;
    logic push1;
    logic pop;
  } fifo_ctl_t;

endpackage

[hw/rtl/llrs_lane.sv]
module llrs_lane (
  input  logic [7:0]                     nbr,
  input  logic                           alive,
  input  logic [llrs_pkg::MASK_BITS-1:0] birth,
  input  logic [llrs_pkg::MASK_BITS-1:0] survive,
  output logic                           next
);

  logic [llrs_pkg::CNT_BITS-1:0]  cnt;
  logic [llrs_pkg::MASK_BITS-1:0] rule;

  always_comb begin
    cnt  = llrs_pkg::CNT_BITS'($countones(nbr));
    rule = alive ? survive : birth;
    next = rule[cnt];
  end

endmodule

[hw/rtl/llrs_row.sv]
module llrs_row #(
  parameter int W = 64
) (
  input  logic [W-1:0]                   up,
  input  logic [W-1:0]                   mid,
  input  logic [W-1:0]                   down,
  input  logic [W-1:0]                   keep,
  input  logic [llrs_pkg::MASK_BITS-1:0] birth,
  input  logic [llrs_pkg::MASK_BITS-1:0] survive,
  output logic [W-1:0]                   next,
  output logic                           changed
);

  logic [W-1:0] lane_out;
  logic         kill;

  for (genvar j = 0; j < W; j++) begin : g_lane
    logic [7:0] nbr;
    logic       ul, ml, dl, ur, mr, dr;
    if (j > 0) begin : g_left
      assign ul = up[j-1];
      assign ml = mid[j-1];
      assign dl = down[j-1];
    end else begin : g_no_left
      assign ul = 1'b0;
      assign ml = 1'b0;
      assign dl = 1'b0;
    end
    if (j < W - 1) begin : g_right
      assign ur = up[j+1];
      assign mr = mid[j+1];
      assign dr = down[j+1];
    end else begin : g_no_right
      assign ur = 1'b0;
      assign mr = 1'b0;
      assign dr = 1'b0;
    end
    assign nbr = {ul, up[j], ur, ml, mr, dl, down[j], dr};
    llrs_lane u_lane (
      .nbr     (nbr),
      .alive   (mid[j]),
      .birth   (birth),
      .survive (survive),
      .next    (lane_out[j])
    );
  end

  // merge lanes into the row result
  always_comb begin
    kill    = (birth == '0) || (survive == '0);
    next    = kill ? '0 : (lane_out & keep);
    changed = |(next ^ mid);
  end

endmodule

[hw/rtl/llrs_fifo.sv]
module llrs_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  llrs_pkg::fifo_ctl_t           ctl,
  input  llrs_pkg::out_t                wdata0,
  input  llrs_pkg::out_t                wdata1,
  output llrs_pkg::out_t                rdata,
  output logic [llrs_pkg::FIFO_CNT-1:0] count
);

  llrs_pkg::out_t                mem [llrs_pkg::FIFO_DEPTH];
  logic [llrs_pkg::FIFO_PTR-1:0] head_r, head_nxt;
  logic [llrs_pkg::FIFO_PTR-1:0] tail_r, tail_nxt;
  logic [llrs_pkg::FIFO_CNT-1:0] count_r, count_nxt;
  logic [llrs_pkg::FIFO_PTR-1:0] tail_p1;

  always_comb begin
    tail_p1   = tail_r + 1'b1;
    head_nxt  = ctl.pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r + llrs_pkg::FIFO_PTR'(ctl.push0) + llrs_pkg::FIFO_PTR'(ctl.push1);
    count_nxt = count_r + llrs_pkg::FIFO_CNT'(ctl.push0) + llrs_pkg::FIFO_CNT'(ctl.push1)
                - llrs_pkg::FIFO_CNT'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push0) begin
      mem[tail_r] <= wdata0;
    end
    if (ctl.push1) begin
      mem[tail_p1] <= wdata1;
    end
  end

  assign rdata = mem[head_r];
  assign count = count_r;

endmodule

[hw/rtl/life_like_automaton_row_step_core.sv]
// one row accepted per cycle while in_stall is low; results are registered in the queue
// a bottom row gives up to two results, drained one per cycle unless out_stall is high
// through a four-entry output queue; rows flow while it has room for two more results
// rst_n is synchronous: board flags and queue clear, rule masks return to 8 and 12,
// board width to 64
module life_like_automaton_row_step_core #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  llrs_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output llrs_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [llrs_pkg::MASK_BITS-1:0]      cfg_data
);

  logic [llrs_pkg::MASK_BITS-1:0]  birth_r, survive_r;
  logic [llrs_pkg::WIDTH_BITS-1:0] board_width_r;
  logic [llrs_pkg::WIDTH_BITS-1:0] w_use;
  logic [MAX_WIDTH-1:0]            keep;

  logic                 started_r, started_nxt;
  logic                 any_change_r, any_change_nxt;
  logic [MAX_WIDTH-1:0] row_above_r, row_above_nxt;
  logic [MAX_WIDTH-1:0] row_middle_r, row_middle_nxt;

  logic                 acc;
  logic [MAX_WIDTH-1:0] row, up, mid;
  logic [MAX_WIDTH-1:0] a_up, a_mid, a_down, a_next, b_next;
  logic                 a_ch, b_ch;
  logic [llrs_pkg::ROW_BITS-1:0] a_wide, b_wide;

  llrs_pkg::fifo_ctl_t           ctl;
  llrs_pkg::out_t                ent0, ent1;
  logic [llrs_pkg::FIFO_CNT-1:0] q_count;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_r       <= llrs_pkg::BIRTH_RESET;
      survive_r     <= llrs_pkg::SURVIVE_RESET;
      board_width_r <= llrs_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (llrs_pkg::cfg_index_t'(cfg_index))
        llrs_pkg::CFG_BIRTH:   birth_r       <= cfg_data;
        llrs_pkg::CFG_SURVIVE: survive_r     <= cfg_data;
        llrs_pkg::CFG_WIDTH:   board_width_r <= cfg_data[llrs_pkg::WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // columns in use
  always_comb begin
    if (board_width_r == '0) begin
      w_use = llrs_pkg::WIDTH_BITS'(1);
    end else if (board_width_r > llrs_pkg::WIDTH_BITS'(MAX_WIDTH)) begin
      w_use = llrs_pkg::WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_use = board_width_r;
    end
  end

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_keep
    assign keep[j] = (llrs_pkg::WIDTH_BITS'(j) < w_use);
  end

  assign in_stall  = (q_count > llrs_pkg::FIFO_CNT'(llrs_pkg::FIFO_DEPTH - 2));
  assign acc       = in_valid && !in_stall;
  assign out_valid = (q_count != '0);

  always_comb begin
    row    = in_data.row_cells[MAX_WIDTH-1:0] & keep;
    up     = row_above_r & keep;
    mid    = row_middle_r & keep;
    a_up   = started_r ? up  : '0;
    a_mid  = started_r ? mid : row;
    a_down = started_r ? row : '0;
  end

  llrs_row #(.W(MAX_WIDTH)) u_row_a (
    .up      (a_up),
    .mid     (a_mid),
    .down    (a_down),
    .keep    (keep),
    .birth   (birth_r),
    .survive (survive_r),
    .next    (a_next),
    .changed (a_ch)
  );

  llrs_row #(.W(MAX_WIDTH)) u_row_b (
    .up      (mid),
    .mid     (row),
    .down    ('0),
    .keep    (keep),
    .birth   (birth_r),
    .survive (survive_r),
    .next    (b_next),
    .changed (b_ch)
  );

  always_comb begin
    a_wide                  = '0;
    a_wide[MAX_WIDTH-1:0]   = a_next;
    b_wide                  = '0;
    b_wide[MAX_WIDTH-1:0]   = b_next;

    ent0.next_cells      = a_wide;
    ent0.row_changed     = a_ch;
    ent0.final_row       = !started_r;
    ent0.board_unchanged = !started_r && !(any_change_r || a_ch);

    ent1.next_cells      = b_wide;
    ent1.row_changed     = b_ch;
    ent1.final_row       = 1'b1;
    ent1.board_unchanged = !(any_change_r || a_ch || b_ch);

    ctl.push0 = acc && (started_r || in_data.last_row);
    ctl.push1 = acc && started_r && in_data.last_row;
    ctl.pop   = out_valid && !out_stall;
  end

  // board state
  always_comb begin
    started_nxt    = started_r;
    any_change_nxt = any_change_r;
    row_above_nxt  = row_above_r;
    row_middle_nxt = row_middle_r;
    if (acc) begin
      if (in_data.last_row) begin
        started_nxt    = 1'b0;
        any_change_nxt = 1'b0;
      end else if (!started_r) begin
        started_nxt    = 1'b1;
        row_above_nxt  = '0;
        row_middle_nxt = row;
      end else begin
        any_change_nxt = any_change_r || a_ch;
        row_above_nxt  = mid;
        row_middle_nxt = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      any_change_r <= 1'b0;
    end else begin
      started_r    <= started_nxt;
      any_change_r <= any_change_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_above_r  <= row_above_nxt;
    row_middle_r <= row_middle_nxt;
  end

  llrs_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .wdata0 (ent0),
    .wdata1 (ent1),
    .rdata  (out_data),
    .count  (q_count)
  );

endmodule

[hw/rtl/llrs_checker.sv]
module llrs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input llrs_pkg::out_t out_data
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_unchanged_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.board_unchanged |-> out_data.final_row)
    else $error("board_unchanged off the final row");

  a_unchanged_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.board_unchanged |-> !out_data.row_changed)
    else $error("unchanged board with a changed row");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("queue not empty after reset");

endmodule

bind life_like_automaton_row_step_core llrs_checker u_llrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
